/* rtl/esud_pkg.sv */
// Shared types, constants and elaboration-time tables for the epoch seconds to UTC date block.
// Used by esud_ctrl, esud_dp and epoch_seconds_to_utc_date; depends on nothing else.
package esud_pkg;

    // Number of supported years, starting with 1900.
    localparam int NUM_YEARS = 256;

    localparam int IN_W      = 40;
    localparam int YI_W      = $clog2(NUM_YEARS);
    localparam int YS_DEPTH  = 2 ** YI_W;
    localparam int YS_W      = $clog2(NUM_YEARS * 366 + 1);

    // Whole days are biased by a multiple of seven so that the dividend is
    // never negative and the weekday needs no correction for the bias.
    localparam longint SECS_PER_DAY = 86400;
    localparam longint DAY_OFS      = 6363028;
    localparam int     DVD_W        = IN_W + 1;
    localparam logic [DVD_W-1:0] DVD_OFS = DVD_W'(DAY_OFS * SECS_PER_DAY);
    localparam int     REM_W        = 17;
    localparam int     Q_W          = 24;
    localparam int     DQ_W         = Q_W + 2;

    // Day split: 86400 is 128 * 675, so the biased seconds lose their low seven
    // bits to a shift and the rest is divided by 675 in two digits, the upper
    // one of 20 bits and the lower one of 14 bits.
    localparam int DAY_SH   = 7;
    localparam int DAY_DIV  = 675;
    localparam int DIG_LO_W = 14;
    localparam int DIG_HI_W = DVD_W - DAY_SH - DIG_LO_W;
    localparam int DR_W     = 10;
    localparam int DQ_HI_W  = 11;

    // Reciprocal constants: floor(x / d) == (x * M) >> S over the value ranges used.
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 26;
    localparam int P_W     = MUL_A_W + MUL_B_W;
    localparam int M_DAY   = 25451659;
    localparam int SH_DAY  = 34;
    localparam int M_HOUR  = 149131;
    localparam int SH_HOUR = 29;
    localparam int M_MIN   = 4370;
    localparam int SH_MIN  = 18;
    localparam int M_WEEK  = 38347923;
    localparam int SH_WEEK = 28;
    localparam int WQ_W    = P_W - SH_WEEK;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_WEEK = 7;
    localparam int EPOCH_WEEKDAY = 4;

    function automatic int leaps_upto(input int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // Day of January 1 of year 1900 + idx, counted from 1900-01-01.
    function automatic int ys_rel(input int idx);
        return 365 * idx + leaps_upto(1899 + idx) - leaps_upto(1899);
    endfunction

    function automatic logic is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    typedef logic [YS_DEPTH-1:0][YS_W-1:0] t_ys_tbl;
    typedef logic [YS_DEPTH-1:0]           t_leap_tbl;
    typedef logic [12:0][8:0]              t_cum_tbl;

    function automatic t_ys_tbl build_ys();
        t_ys_tbl tbl;
        for (int i = 0; i < YS_DEPTH; i++) begin
            if (i < NUM_YEARS) begin
                tbl[i] = YS_W'(ys_rel(i));
            end else begin
                tbl[i] = '1;
            end
        end
        return tbl;
    endfunction

    function automatic t_leap_tbl build_leap();
        t_leap_tbl tbl;
        for (int i = 0; i < YS_DEPTH; i++) begin
            tbl[i] = is_leap(1900 + i);
        end
        return tbl;
    endfunction

    localparam t_ys_tbl   YEAR_START = build_ys();
    localparam t_leap_tbl LEAP_YEAR  = build_leap();
    localparam int        YS_LAST    = ys_rel(NUM_YEARS - 1);
    localparam int        EPOCH_DAY  = ys_rel(70);
    localparam int        DQ_OFS     = int'(DAY_OFS) - EPOCH_DAY;

    localparam t_cum_tbl CUM_COMMON = {9'd365, 9'd334, 9'd304, 9'd273, 9'd243, 9'd212,
                                       9'd181, 9'd151, 9'd120, 9'd90, 9'd59, 9'd31, 9'd0};
    localparam t_cum_tbl CUM_LEAP   = {9'd366, 9'd335, 9'd305, 9'd274, 9'd244, 9'd213,
                                       9'd182, 9'd152, 9'd121, 9'd91, 9'd60, 9'd31, 9'd0};

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DAY_MUL1,
        OP_DAY_BK1,
        OP_DAY_REM1,
        OP_DAY_MUL2,
        OP_DAY_BK2,
        OP_DAY_REM2,
        OP_MUL_H,
        OP_MUL_H2,
        OP_REM_H,
        OP_MUL_M,
        OP_MUL_M2,
        OP_SEC,
        OP_MUL_W2,
        OP_WDAY,
        OP_YEAR,
        OP_YDAY,
        OP_MONTH
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            out_load;
        logic [YI_W-1:0] year_bit;
    } t_dp_cmd;

endpackage

/* rtl/esud_dp.sv */
// Datapath: reciprocal day divider, shared reciprocal multiplier, year search and month lookup.
// Driven by esud_ctrl through t_dp_cmd; depends on esud_pkg.
module esud_dp (
    input  logic                       i_clk,
    input  esud_pkg::t_dp_cmd          i_cmd,
    input  logic [esud_pkg::IN_W-1:0]  i_epoch_seconds,
    output logic [5:0]                 o_second,
    output logic [5:0]                 o_minute,
    output logic [4:0]                 o_hour,
    output logic [4:0]                 o_month_day,
    output logic [3:0]                 o_month,
    output logic [7:0]                 o_year_since_1900,
    output logic [2:0]                 o_weekday,
    output logic [8:0]                 o_year_day,
    output logic                       o_out_of_range
);
    import esud_pkg::*;

    logic [DVD_W-1:0]   r_dvd;
    logic [MUL_A_W-1:0] r_z;
    logic [DQ_HI_W-1:0] r_qhi;
    logic [DIG_LO_W-1:0] r_qlo;
    logic [REM_W-1:0]   r_rem;
    logic [P_W-1:0]     r_prod;
    logic [4:0]         r_hour;
    logic [11:0]        r_rem2;
    logic [5:0]         r_minute;
    logic [5:0]         r_second;
    logic [2:0]         r_weekday;
    logic [YS_W-1:0]    r_dq;
    logic               r_oor;
    logic [YI_W-1:0]    r_yi;
    logic [8:0]         r_yday;
    logic               r_leap;
    logic [3:0]         r_month;
    logic [4:0]         r_mday;

    logic [5:0]         r_o_second;
    logic [5:0]         r_o_minute;
    logic [4:0]         r_o_hour;
    logic [4:0]         r_o_mday;
    logic [3:0]         r_o_month;
    logic [7:0]         r_o_year;
    logic [2:0]         r_o_weekday;
    logic [8:0]         r_o_yday;
    logic               r_o_oor;

    logic [Q_W-1:0]     q;
    logic [Q_W-1:0]     qp4;
    logic [DIG_LO_W-1:0] dig_q;
    logic [DQ_W-1:0]    dq_full;
    logic               oor_c;
    logic [4:0]         hour_c;
    logic [5:0]         minute_c;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [P_W-1:0]     product;
    logic [YI_W-1:0]    cand;
    t_cum_tbl           cum;
    logic [3:0]         month_c;
    logic [4:0]         mday_c;

    // The day count is the upper quotient digit followed by the lower one.
    assign q       = Q_W'({r_qhi, r_qlo});
    assign qp4     = q + Q_W'(EPOCH_WEEKDAY);
    assign dig_q   = r_prod[SH_DAY +: DIG_LO_W];

    // Day offset from 1900-01-01; negative or past the last year start is out of range.
    assign dq_full  = {2'b00, q} - DQ_W'(DQ_OFS);
    assign oor_c    = dq_full[DQ_W-1] || (dq_full > DQ_W'(YS_LAST));
    assign hour_c   = r_prod[SH_HOUR +: 5];
    assign minute_c = r_prod[SH_MIN +: 6];
    assign cand     = r_yi | i_cmd.year_bit;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_DAY_MUL1: begin
                mul_a = MUL_A_W'(r_dvd[DVD_W-1 -: DIG_HI_W]);
                mul_b = MUL_B_W'(M_DAY);
            end
            OP_DAY_MUL2: begin
                mul_a = r_z;
                mul_b = MUL_B_W'(M_DAY);
            end
            OP_DAY_BK1, OP_DAY_BK2: begin
                mul_a = MUL_A_W'(dig_q);
                mul_b = MUL_B_W'(DAY_DIV);
            end
            OP_MUL_H: begin
                mul_a = MUL_A_W'(r_rem);
                mul_b = MUL_B_W'(M_HOUR);
            end
            OP_MUL_H2: begin
                mul_a = MUL_A_W'(hour_c);
                mul_b = MUL_B_W'(SECS_PER_HOUR);
            end
            OP_MUL_M: begin
                mul_a = MUL_A_W'(r_rem2);
                mul_b = MUL_B_W'(M_MIN);
            end
            OP_MUL_M2: begin
                mul_a = MUL_A_W'(minute_c);
                mul_b = MUL_B_W'(SECS_PER_MIN);
            end
            OP_SEC: begin
                mul_a = MUL_A_W'(qp4);
                mul_b = MUL_B_W'(M_WEEK);
            end
            OP_MUL_W2: begin
                mul_a = MUL_A_W'(r_prod[SH_WEEK +: WQ_W]);
                mul_b = MUL_B_W'(DAYS_PER_WEEK);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = P_W'(mul_a) * P_W'(mul_b);

    // Month is the number of cumulative month starts that the day of year has reached.
    always_comb begin
        cum     = r_leap ? CUM_LEAP : CUM_COMMON;
        month_c = '0;
        for (int k = 1; k < 12; k++) begin
            month_c = month_c + 4'(r_yday >= cum[k]);
        end
        mday_c = 5'(r_yday - cum[month_c] + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_dvd <= {i_epoch_seconds[IN_W-1], i_epoch_seconds} + DVD_OFS;
            end
            OP_DAY_MUL1, OP_DAY_MUL2: begin
                r_prod <= product;
            end
            OP_DAY_BK1: begin
                r_prod <= product;
                r_qhi  <= DQ_HI_W'(dig_q);
            end
            OP_DAY_BK2: begin
                r_prod <= product;
                r_qlo  <= dig_q;
            end
            OP_DAY_REM1: begin
                r_z <= {DR_W'(r_dvd[DVD_W-1 -: DIG_HI_W] - r_prod[DIG_HI_W-1:0]),
                        r_dvd[DAY_SH +: DIG_LO_W]};
            end
            OP_DAY_REM2: begin
                r_rem <= {DR_W'(r_z - r_prod[MUL_A_W-1:0]), r_dvd[DAY_SH-1:0]};
            end
            OP_MUL_H: begin
                r_prod <= product;
                r_dq   <= dq_full[YS_W-1:0];
                r_oor  <= oor_c;
            end
            OP_MUL_H2: begin
                r_prod <= product;
                r_hour <= hour_c;
            end
            OP_REM_H: begin
                r_rem2 <= 12'(r_rem - r_prod[REM_W-1:0]);
            end
            OP_MUL_M: begin
                r_prod <= product;
            end
            OP_MUL_M2: begin
                r_prod   <= product;
                r_minute <= minute_c;
            end
            OP_SEC: begin
                r_prod   <= product;
                r_second <= 6'(r_rem2 - r_prod[11:0]);
            end
            OP_MUL_W2: begin
                r_prod <= product;
            end
            OP_WDAY: begin
                r_weekday <= 3'(qp4 - r_prod[Q_W-1:0]);
                r_yi      <= '0;
            end
            OP_YEAR: begin
                if (YEAR_START[cand] <= r_dq) begin
                    r_yi <= cand;
                end
            end
            OP_YDAY: begin
                r_yday <= 9'(r_dq - YEAR_START[r_yi]);
                r_leap <= LEAP_YEAR[r_yi];
            end
            OP_MONTH: begin
                r_month <= month_c;
                r_mday  <= mday_c;
            end
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            r_o_oor     <= r_oor;
            r_o_second  <= r_oor ? '0 : r_second;
            r_o_minute  <= r_oor ? '0 : r_minute;
            r_o_hour    <= r_oor ? '0 : r_hour;
            r_o_mday    <= r_oor ? '0 : r_mday;
            r_o_month   <= r_oor ? '0 : r_month;
            r_o_year    <= r_oor ? '0 : 8'(r_yi);
            r_o_weekday <= r_oor ? '0 : r_weekday;
            r_o_yday    <= r_oor ? '0 : r_yday;
        end
    end

    assign o_second          = r_o_second;
    assign o_minute          = r_o_minute;
    assign o_hour            = r_o_hour;
    assign o_month_day       = r_o_mday;
    assign o_month           = r_o_month;
    assign o_year_since_1900 = r_o_year;
    assign o_weekday         = r_o_weekday;
    assign o_year_day        = r_o_yday;
    assign o_out_of_range    = r_o_oor;

endmodule

/* rtl/esud_ctrl.sv */
// Controller: sequences the datapath through division, field extraction and year search.
// Issues t_dp_cmd to esud_dp and runs both handshakes; depends on esud_pkg.
module esud_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output esud_pkg::t_dp_cmd o_cmd
);
    import esud_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_DAY_MUL1 = 19'h00002,
        S_DAY_BK1  = 19'h00004,
        S_DAY_REM1 = 19'h00008,
        S_DAY_MUL2 = 19'h00010,
        S_DAY_BK2  = 19'h00020,
        S_DAY_REM2 = 19'h00040,
        S_MUL_H    = 19'h00080,
        S_MUL_H2   = 19'h00100,
        S_REM_H    = 19'h00200,
        S_MUL_M    = 19'h00400,
        S_MUL_M2   = 19'h00800,
        S_SEC      = 19'h01000,
        S_MUL_W2   = 19'h02000,
        S_WDAY     = 19'h04000,
        S_YEAR     = 19'h08000,
        S_YDAY     = 19'h10000,
        S_MONTH    = 19'h20000,
        S_FIN      = 19'h40000
    } t_state;

    t_state                r_state, n_state;
    logic [YI_W-1:0]       r_mask, n_mask;
    logic                  r_out_valid, n_out_valid;
    t_dp_cmd               cmd;

    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        cmd.op       = OP_IDLE;
        cmd.out_load = 1'b0;
        cmd.year_bit = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_LOAD;
                    n_state = S_DAY_MUL1;
                end
            end
            S_DAY_MUL1: begin
                cmd.op  = OP_DAY_MUL1;
                n_state = S_DAY_BK1;
            end
            S_DAY_BK1: begin
                cmd.op  = OP_DAY_BK1;
                n_state = S_DAY_REM1;
            end
            S_DAY_REM1: begin
                cmd.op  = OP_DAY_REM1;
                n_state = S_DAY_MUL2;
            end
            S_DAY_MUL2: begin
                cmd.op  = OP_DAY_MUL2;
                n_state = S_DAY_BK2;
            end
            S_DAY_BK2: begin
                cmd.op  = OP_DAY_BK2;
                n_state = S_DAY_REM2;
            end
            S_DAY_REM2: begin
                cmd.op  = OP_DAY_REM2;
                n_state = S_MUL_H;
            end
            S_MUL_H: begin
                cmd.op  = OP_MUL_H;
                n_state = S_MUL_H2;
            end
            S_MUL_H2: begin
                cmd.op  = OP_MUL_H2;
                n_state = S_REM_H;
            end
            S_REM_H: begin
                cmd.op  = OP_REM_H;
                n_state = S_MUL_M;
            end
            S_MUL_M: begin
                cmd.op  = OP_MUL_M;
                n_state = S_MUL_M2;
            end
            S_MUL_M2: begin
                cmd.op  = OP_MUL_M2;
                n_state = S_SEC;
            end
            S_SEC: begin
                cmd.op  = OP_SEC;
                n_state = S_MUL_W2;
            end
            S_MUL_W2: begin
                cmd.op  = OP_MUL_W2;
                n_state = S_WDAY;
            end
            S_WDAY: begin
                cmd.op  = OP_WDAY;
                n_mask  = YI_W'(1) << (YI_W - 1);
                n_state = S_YEAR;
            end
            S_YEAR: begin
                cmd.op       = OP_YEAR;
                cmd.year_bit = r_mask;
                n_mask       = r_mask >> 1;
                if (r_mask[0]) begin
                    n_state = S_YDAY;
                end
            end
            S_YDAY: begin
                cmd.op  = OP_YDAY;
                n_state = S_MONTH;
            end
            S_MONTH: begin
                cmd.op  = OP_MONTH;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = cmd.out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

`ifndef SYNTH
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DAY_MUL1))
        else $error("accepted word did not start the divider");

    a_div_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_H) |-> ($past(r_state) == S_DAY_REM2))
        else $error("divider left before both quotient digits were formed");

    a_year_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> $onehot(r_mask))
        else $error("year search bit mask is not one-hot");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register loaded while a stalled word waits");
`endif

endmodule

/* rtl/epoch_seconds_to_utc_date.sv */
// Top level of the epoch seconds to UTC date converter.
// Instantiates esud_ctrl and esud_dp; depends on esud_pkg.

// This block turns a signed 40-bit count of seconds since 1970-01-01 00:00:00
// UTC into broken-down UTC time on the Gregorian calendar: second, minute,
// hour, day of month, month, year since 1900, weekday and day of year. A
// negative count is floored, so a time before the epoch lands on the correct
// earlier day. The supported span runs from 1900-01-01 through the first day
// of year 1900 + NUM_YEARS - 1; a word outside it comes back with
// out_of_range set and every other field zero. The block handles one word at
// a time in these steps: the first takes and biases the word, the day split
// drops the low seven bits and divides the rest by 675 in two digits, each by
// reciprocal multiplication, a multiply back and a remainder, followed by
// eight steps on one shared multiplier for hour, minute, second and weekday,
// one step per bit of the year search over the table of year starts, and
// final steps for day of year, month and the result register. A finished
// result sits in an output register, so the next word is accepted while the
// last one still waits to be taken.
module epoch_seconds_to_utc_date (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [esud_pkg::IN_W-1:0] i_epoch_seconds,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [5:0]                o_second,
    output logic [5:0]                o_minute,
    output logic [4:0]                o_hour,
    output logic [4:0]                o_month_day,
    output logic [3:0]                o_month,
    output logic [7:0]                o_year_since_1900,
    output logic [2:0]                o_weekday,
    output logic [8:0]                o_year_day,
    output logic                      o_out_of_range
);
    import esud_pkg::*;

    // Command word from the sequencer to the datapath, one operation per cycle.
    t_dp_cmd cmd;

    esud_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds the input word from acceptance onward and keeps the
    // finished result in its own output register.
    esud_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .i_epoch_seconds   (i_epoch_seconds),
        .o_second          (o_second),
        .o_minute          (o_minute),
        .o_hour            (o_hour),
        .o_month_day       (o_month_day),
        .o_month           (o_month),
        .o_year_since_1900 (o_year_since_1900),
        .o_weekday         (o_weekday),
        .o_year_day        (o_year_day),
        .o_out_of_range    (o_out_of_range)
    );

endmodule
